### rtl/delayed_message_queue_dedup_macros.svh
// Assertion macros for the delayed message queue.
// Included by the top level; no other dependencies.
`ifndef DELAYED_MESSAGE_QUEUE_DEDUP_MACROS_SVH
`define DELAYED_MESSAGE_QUEUE_DEDUP_MACROS_SVH
`ifndef SYNTHESIS
`define DMQ_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define DMQ_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define DMQ_ASSERT_IMPL(label, clk, rst_n, prop)
`define DMQ_ASSERT_RST(label, clk, prop)
`endif
`endif

### rtl/dmq_pkg.sv
// Package for the delayed message queue: result kinds, field widths, defaults.
// No dependencies.
`default_nettype none
package dmq_pkg;
    localparam int QueueDepthDefault = 16;
    localparam int MaxResults        = 16;

    typedef enum logic [2:0] {
        KIND_IMMEDIATE = 3'd0,
        KIND_DELAYED   = 3'd1,
        KIND_DUPLICATE = 3'd2,
        KIND_FULL      = 3'd3,
        KIND_STORED    = 3'd4,
        KIND_NONE_DUE  = 3'd5
    } t_kind;

    localparam logic OP_SEND = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Message body: name, receiver, sender, scope (49 bits)
    typedef struct packed {
        logic [8:0]  scope;
        logic [15:0] sender;
        logic [15:0] receiver;
        logic [7:0]  name;
    } t_msg;
endpackage
`default_nettype wire

### rtl/delayed_message_queue_dedup.sv
// Delayed message queue with duplicate suppression, top level.
// Depends on dmq_pkg and delayed_message_queue_dedup_macros.svh.
//
// Usage: one input transaction on the s_axis channel is either a send or a
// tick (tuser = opcode). A send with delay zero yields one immediate result;
// otherwise the table is walked once for a duplicate, then the message is
// stored (due = now + delay, saturating) or refused when full. A tick walks
// the table oldest first, emits every due entry (at most 16 per tick) and
// compacts the survivors in place; with nothing due it emits one "none due"
// result. tlast marks the final result of each input transaction.
// An immediate send shows its result in the cycle after acceptance; any
// other send compares the stored entries in turn, stopping at a duplicate,
// before its result. A tick visits one entry per cycle unless a stalled
// receiver holds it; each delivery is held back in a holding register so
// that tlast can be set on the final one.
// s_axis_tready is low from acceptance until the final result is taken, so a
// new item waits until the last one has fully left. A stalled receiver
// holds the walk at the next due entry. After reset the table is empty and
// the block is ready at once; no clearing pass is needed.
`default_nettype none
`include "delayed_message_queue_dedup_macros.svh"
module delayed_message_queue_dedup #(
    parameter int QUEUE_DEPTH = dmq_pkg::QueueDepthDefault
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: now[31:0], delay[51:32], name[59:52], receiver_id[75:60],
    //        sender_id[91:76], scope_state[100:92], zero fill [103:101]
    input  wire [103:0] s_axis_tdata,
    // tuser: opcode
    input  wire         s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // tdata: out_msg_name[7:0], out_receiver_id[23:8], out_sender_id[39:24],
    //        out_scope_state[48:40], zero fill [55:49]
    output logic [55:0] m_axis_tdata,
    // tuser: result_kind
    output logic [2:0]  m_axis_tuser,
    output logic        m_axis_tlast
);
    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int NW = $clog2(dmq_pkg::MaxResults + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DUP  = 3'b010,
        ST_TICK = 3'b100
    } t_state;

    t_state r_state, n_state;

    // table storage
    logic [31:0]       r_due [QUEUE_DEPTH];
    dmq_pkg::t_msg     r_msg [QUEUE_DEPTH];
    logic [CW-1:0]     r_count, n_count;

    // registered read port of the table
    logic [31:0]       r_rdue;
    dmq_pkg::t_msg     r_rmsg;

    // item registers
    logic [31:0]       r_now;
    logic [31:0]       r_newdue;
    dmq_pkg::t_msg     r_in;
    logic [CW-1:0]     r_rd, n_rd;
    logic [CW-1:0]     r_wr, n_wr;
    logic [NW-1:0]     r_n, n_n;
    dmq_pkg::t_msg     r_hmsg, n_hmsg;

    // output register
    logic              r_ovalid, n_ovalid;
    dmq_pkg::t_kind    r_okind, n_okind;
    dmq_pkg::t_msg     r_omsg, n_omsg;
    logic              r_olast, n_olast;

    logic [IW-1:0]     w_rd_idx;
    logic [IW-1:0]     w_wi;
    logic [IW-1:0]     w_ci;
    logic              w_more;
    logic              w_match;
    logic              w_due;
    logic              w_out_free;
    logic              w_wr_en;
    logic [IW-1:0]     w_wr_idx;
    logic [31:0]       w_wr_due;
    dmq_pkg::t_msg     w_wr_msg;
    logic [32:0]       w_sum;
    dmq_pkg::t_msg     w_smsg;

    assign w_rd_idx = n_rd[IW-1:0];
    assign w_wi     = r_wr[IW-1:0];
    assign w_ci     = r_count[IW-1:0];
    assign w_more   = (r_rd < r_count);
    // shared compare unit on the entry under the read pointer
    assign w_match    = (r_rmsg == r_in);
    assign w_due      = (r_rdue <= r_now);
    assign w_out_free = !r_ovalid || m_axis_tready;
    assign w_sum  = {1'b0, s_axis_tdata[31:0]} + {13'd0, s_axis_tdata[51:32]};
    assign w_smsg = s_axis_tdata[100:52];

    assign s_axis_tready = (r_state == ST_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {7'd0, r_omsg};
    assign m_axis_tuser  = r_okind;
    assign m_axis_tlast  = r_olast;

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_rd     = r_rd;
        n_wr     = r_wr;
        n_n      = r_n;
        n_hmsg   = r_hmsg;
        n_ovalid = r_ovalid && !m_axis_tready;
        n_okind  = r_okind;
        n_omsg   = r_omsg;
        n_olast  = r_olast;
        w_wr_en  = 1'b0;
        w_wr_idx = w_ci;
        w_wr_due = r_newdue;
        w_wr_msg = r_in;
        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    n_rd = '0;
                    n_wr = '0;
                    n_n  = '0;
                    if (s_axis_tuser == dmq_pkg::OP_TICK) begin
                        n_state = ST_TICK;
                    end else if (s_axis_tdata[51:32] == 20'd0) begin
                        n_ovalid = 1'b1;
                        n_okind  = dmq_pkg::KIND_IMMEDIATE;
                        n_omsg   = w_smsg;
                        n_olast  = 1'b1;
                    end else begin
                        n_state = ST_DUP;
                    end
                end
            end
            ST_DUP: begin
                n_omsg  = r_in;
                n_olast = 1'b1;
                if (w_more && w_match) begin
                    n_ovalid = 1'b1;
                    n_okind  = dmq_pkg::KIND_DUPLICATE;
                    n_state  = ST_IDLE;
                end else if (w_more) begin
                    n_rd = r_rd + 1'b1;
                end else if (r_count == CW'(QUEUE_DEPTH)) begin
                    n_ovalid = 1'b1;
                    n_okind  = dmq_pkg::KIND_FULL;
                    n_state  = ST_IDLE;
                end else begin
                    w_wr_en  = 1'b1;
                    n_count  = r_count + 1'b1;
                    n_ovalid = 1'b1;
                    n_okind  = dmq_pkg::KIND_STORED;
                    n_state  = ST_IDLE;
                end
            end
            ST_TICK: begin
                // walk: hold each due entry, release the previous one, compact the rest
                if (w_more) begin
                    if (w_due && r_n != NW'(dmq_pkg::MaxResults)) begin
                        if (r_n == '0 || w_out_free) begin
                            if (r_n != '0) begin
                                n_ovalid = 1'b1;
                                n_okind  = dmq_pkg::KIND_DELAYED;
                                n_omsg   = r_hmsg;
                                n_olast  = 1'b0;
                            end
                            n_hmsg = r_rmsg;
                            n_n    = r_n + 1'b1;
                            n_rd   = r_rd + 1'b1;
                        end
                    end else begin
                        w_wr_en  = 1'b1;
                        w_wr_idx = w_wi;
                        w_wr_due = r_rdue;
                        w_wr_msg = r_rmsg;
                        n_wr     = r_wr + 1'b1;
                        n_rd     = r_rd + 1'b1;
                    end
                end else if (w_out_free) begin
                    // release the held delivery as the final one, or report none due
                    n_count  = r_wr;
                    n_state  = ST_IDLE;
                    n_ovalid = 1'b1;
                    n_olast  = 1'b1;
                    if (r_n == '0) begin
                        n_okind = dmq_pkg::KIND_NONE_DUE;
                        n_omsg  = '0;
                    end else begin
                        n_okind = dmq_pkg::KIND_DELAYED;
                        n_omsg  = r_hmsg;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_rd     <= '0;
            r_wr     <= '0;
            r_n      <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
            r_rd     <= n_rd;
            r_wr     <= n_wr;
            r_n      <= n_n;
        end
    end

    // payload registers, table reads and table writes
    always_ff @(posedge i_clk) begin
        r_okind <= n_okind;
        r_omsg  <= n_omsg;
        r_olast <= n_olast;
        r_hmsg  <= n_hmsg;
        r_rdue  <= r_due[w_rd_idx];
        r_rmsg  <= r_msg[w_rd_idx];
        if (s_axis_tvalid && s_axis_tready) begin
            r_now    <= s_axis_tdata[31:0];
            r_in     <= w_smsg;
            r_newdue <= w_sum[32] ? 32'hFFFF_FFFF : w_sum[31:0];
        end
        if (w_wr_en) begin
            r_due[w_wr_idx] <= w_wr_due;
            r_msg[w_wr_idx] <= w_wr_msg;
        end
    end

    `DMQ_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, r_count <= CW'(QUEUE_DEPTH))
    `DMQ_ASSERT_IMPL(a_wr_behind_rd, i_clk, i_rst_n, r_wr <= r_rd)
    `DMQ_ASSERT_IMPL(a_busy_not_ready, i_clk, i_rst_n,
        (r_state != ST_IDLE) |-> !s_axis_tready)
    `DMQ_ASSERT_IMPL(a_send_store, i_clk, i_rst_n,
        (r_state == ST_DUP && !w_more
         && r_count != CW'(QUEUE_DEPTH)) |=> (r_count == $past(r_count) + 1'b1))
    `DMQ_ASSERT_IMPL(a_out_hold, i_clk, i_rst_n,
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid
         && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    `DMQ_ASSERT_RST(a_reset_empty, i_clk, !$past(i_rst_n) |-> (r_count == '0))
endmodule
`default_nettype wire
